// File: rtl/core/iplpt_pkg.sv
package iplpt_pkg;

  localparam int ADDR_W   = 32;
  localparam int PREFIX_W = 6;
  localparam int VIP_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [PREFIX_W-1:0] PREFIX_MAX = PREFIX_W'(32);

  // command codes, code 3 behaves as a lookup
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE_ADD = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE     = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ADDED     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_WRITE
  } state_t;

  // one table row as held in memory
  typedef struct packed {
    logic                valid;
    logic [ADDR_W-1:0]   address;
    logic [PREFIX_W-1:0] prefix;
    logic [VIP_W-1:0]    vip;
  } entry_t;

  // leading-ones mask for a prefix length of 0 to 32
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PREFIX_W-1:0] len);
    logic [ADDR_W-1:0] m;
    if (len == '0) begin
      m = '0;
    end else if (len >= PREFIX_MAX) begin
      m = '1;
    end else begin
      m = {ADDR_W{1'b1}} << (PREFIX_MAX - len);
    end
    return m;
  endfunction

endpackage

// File: rtl/core/ipv4_longest_prefix_table.sv
// channel | signals                                            | direction
// --------+----------------------------------------------------+----------
// in      | in_valid in_ready command address prefix_length    | input word
//         | virtual_ip                                         |
// out     | out_valid out_ready hit status match_address       | result word
//         | match_prefix match_vip                             |
//
// each word passes through accept, one memory read per entry through the
// single read port, a drain of the read pipeline, and a write-back that
// loads the result register.
// after reset a clearing pass invalidates every row, in_ready low
// a result waiting on out_ready holds the write-back cycle; the next word is
// accepted while the previous result still sits in the output register.
module ipv4_longest_prefix_table #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [iplpt_pkg::CMD_W-1:0]        command,
  input  logic [iplpt_pkg::ADDR_W-1:0]       address,
  input  logic [iplpt_pkg::PREFIX_W-1:0]     prefix_length,
  input  logic [iplpt_pkg::VIP_W-1:0]        virtual_ip,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit,
  output logic [iplpt_pkg::STATUS_W-1:0]     status,
  output logic [iplpt_pkg::ADDR_W-1:0]       match_address,
  output logic [iplpt_pkg::PREFIX_W-1:0]     match_prefix,
  output logic [iplpt_pkg::VIP_W-1:0]        match_vip
);
  import iplpt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // table storage
  entry_t mem [TABLE_ENTRIES];
  entry_t rd_data;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;

  state_t state, state_next;
  logic [IDX_W-1:0] scan_cnt;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;

  // captured word
  logic [CMD_W-1:0]    cmd_q;
  logic [ADDR_W-1:0]   addr_q;
  logic [PREFIX_W-1:0] plen_q;
  logic [VIP_W-1:0]    vip_q;

  // best cover and first free row seen so far
  logic                best_found;
  logic [IDX_W-1:0]    best_idx;
  logic [ADDR_W-1:0]   best_addr;
  logic [PREFIX_W-1:0] best_prefix;
  logic [VIP_W-1:0]    best_vip;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;

  logic covers;
  logic better;
  logic take_best;
  logic take_free;
  logic load_out;

  logic                res_hit;
  logic [STATUS_W-1:0] res_status;
  logic [ADDR_W-1:0]   res_addr;
  logic [PREFIX_W-1:0] res_prefix;
  logic [VIP_W-1:0]    res_vip;

  // memory ports, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[scan_cnt];
  end

  // compare the row coming out of memory against the best so far
  always_comb begin
    covers = rd_data.valid &&
             (((addr_q ^ rd_data.address) & prefix_mask(rd_data.prefix)) == '0);
    better = !best_found || (rd_data.prefix > best_prefix) ||
             ((rd_data.prefix == best_prefix) && (rd_data.address < best_addr));
    take_best = cmp_vld && covers && better;
    take_free = cmp_vld && !rd_data.valid && !free_found;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state, write-back and result
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = scan_cnt;
    mem_wdata  = '0;
    load_out   = 1'b0;
    res_hit    = 1'b0;
    res_status = STATUS_NOT_FOUND;
    res_addr   = '0;
    res_prefix = '0;
    res_vip    = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
        if (scan_cnt == LAST_IDX) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt == LAST_IDX) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        state_next = ST_WRITE;
      end
      ST_WRITE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
          case (cmd_q)
            CMD_UPDATE_ADD: begin
              if (best_found) begin
                mem_we     = 1'b1;
                mem_waddr  = best_idx;
                mem_wdata  = '{valid: 1'b1, address: best_addr,
                               prefix: best_prefix, vip: vip_q};
                res_hit    = 1'b1;
                res_status = STATUS_FOUND;
                res_addr   = best_addr;
                res_prefix = best_prefix;
                res_vip    = vip_q;
              end else if (free_found) begin
                mem_we     = 1'b1;
                mem_waddr  = free_idx;
                mem_wdata  = '{valid: 1'b1, address: addr_q,
                               prefix: plen_q, vip: vip_q};
                res_status = STATUS_ADDED;
                res_addr   = addr_q;
                res_prefix = plen_q;
                res_vip    = vip_q;
              end else begin
                res_status = STATUS_FULL;
              end
            end
            CMD_DELETE: begin
              if (best_found) begin
                mem_we     = 1'b1;
                mem_waddr  = best_idx;
                mem_wdata  = '0;
                res_hit    = 1'b1;
                res_status = STATUS_FOUND;
                res_addr   = best_addr;
                res_prefix = best_prefix;
                res_vip    = best_vip;
              end
            end
            default: begin
              if (best_found) begin
                res_hit    = 1'b1;
                res_status = STATUS_FOUND;
                res_addr   = best_addr;
                res_prefix = best_prefix;
                res_vip    = best_vip;
              end
            end
          endcase
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // scan counter and read pipeline tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt <= '0;
      cmp_vld  <= 1'b0;
    end else begin
      cmp_vld <= (state == ST_SCAN);
      if ((state == ST_CLEAR) || (state == ST_SCAN)) begin
        scan_cnt <= (scan_cnt == LAST_IDX) ? '0 : scan_cnt + 1'b1;
      end
    end
    cmp_idx <= scan_cnt;
  end

  // word capture and best / free tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else if (in_ready && in_valid) begin
      best_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (take_best) begin
        best_found <= 1'b1;
      end
      if (take_free) begin
        free_found <= 1'b1;
      end
    end
    if (in_ready && in_valid) begin
      cmd_q  <= command;
      addr_q <= address;
      plen_q <= (prefix_length > PREFIX_MAX) ? PREFIX_MAX : prefix_length;
      vip_q  <= virtual_ip;
    end
    if (take_best) begin
      best_idx    <= cmp_idx;
      best_addr   <= rd_data.address;
      best_prefix <= rd_data.prefix;
      best_vip    <= rd_data.vip;
    end
    if (take_free) begin
      free_idx <= cmp_idx;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (load_out) begin
      hit           <= res_hit;
      status        <= res_status;
      match_address <= res_addr;
      match_prefix  <= res_prefix;
      match_vip     <= res_vip;
    end
  end

endmodule

// File: test/ipv4_longest_prefix_table_tb.sv
`timescale 1ns / 1ps

module ipv4_longest_prefix_table_tb;
  import iplpt_pkg::*;

  localparam int TABLE_ENTRIES   = 16;
  localparam int TOTAL_WORDS     = 600;
  localparam int QUIET_TAIL      = 80;
  localparam int PRESSURE_AT     = 60;
  localparam int PRESSURE_CYCLES = 300;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int POOL_SIZE       = 12;

  // the spare command code, handled by the block as a lookup
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [ADDR_W-1:0]   address;
    logic [PREFIX_W-1:0] prefix_length;
    logic [VIP_W-1:0]    virtual_ip;
  } lpm_word_t;

  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [PREFIX_W-1:0] prefix;
    logic [VIP_W-1:0]    vip;
  } lpm_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [CMD_W-1:0]      command = '0;
  logic [ADDR_W-1:0]     address = '0;
  logic [PREFIX_W-1:0]   prefix_length = '0;
  logic [VIP_W-1:0]      virtual_ip = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  hit;
  logic [STATUS_W-1:0]   status;
  logic [ADDR_W-1:0]     match_address;
  logic [PREFIX_W-1:0]   match_prefix;
  logic [VIP_W-1:0]      match_vip;

  // shadow copy of the subnet table
  logic                  tbl_valid  [TABLE_ENTRIES];
  logic [ADDR_W-1:0]     tbl_addr   [TABLE_ENTRIES];
  logic [PREFIX_W-1:0]   tbl_prefix [TABLE_ENTRIES];
  logic [VIP_W-1:0]      tbl_vip    [TABLE_ENTRIES];

  lpm_word_t             pending_words[$];
  lpm_result_t           expected_matches[$];
  logic [ADDR_W-1:0]     addr_pool [POOL_SIZE];

  int                    n_accepted = 0;
  int                    n_results = 0;
  int                    errors = 0;
  int                    idle_cycles = 0;
  logic                  quiet = 1'b0;

  ipv4_longest_prefix_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .address      (address),
    .prefix_length(prefix_length),
    .virtual_ip   (virtual_ip),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .hit          (hit),
    .status       (status),
    .match_address(match_address),
    .match_prefix (match_prefix),
    .match_vip    (match_vip)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // leading ones for a stored prefix length
  function automatic logic [ADDR_W-1:0] cover_mask(input logic [PREFIX_W-1:0] len);
    if (len == '0) begin
      return '0;
    end else if (len >= PREFIX_MAX) begin
      return '1;
    end
    return ~({ADDR_W{1'b1}} >> len);
  endfunction

  // search for the longest covering subnet, apply the command, return the result word
  function automatic lpm_result_t match_and_update(input lpm_word_t w);
    lpm_result_t r;
    int best;
    int slot;
    logic [PREFIX_W-1:0] plen;
    best = -1;
    slot = -1;
    r = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && ((w.address ^ tbl_addr[i]) & cover_mask(tbl_prefix[i])) == '0) begin
        if (best < 0 || tbl_prefix[i] > tbl_prefix[best] ||
            (tbl_prefix[i] == tbl_prefix[best] && tbl_addr[i] < tbl_addr[best])) begin
          best = i;
        end
      end
    end
    plen = (w.prefix_length > PREFIX_MAX) ? PREFIX_MAX : w.prefix_length;
    case (w.command)
      CMD_UPDATE_ADD: begin
        if (best >= 0) begin
          tbl_vip[best] = w.virtual_ip;
          slot = best;
          r.hit = 1'b1;
          r.status = STATUS_FOUND;
        end else begin
          for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
            if (!tbl_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            tbl_valid[slot]  = 1'b1;
            tbl_addr[slot]   = w.address;
            tbl_prefix[slot] = plen;
            tbl_vip[slot]    = w.virtual_ip;
            r.status = STATUS_ADDED;
          end else begin
            r.status = STATUS_FULL;
          end
        end
      end
      CMD_DELETE: begin
        if (best >= 0) begin
          slot = best;
          tbl_valid[best] = 1'b0;
          r.hit = 1'b1;
          r.status = STATUS_FOUND;
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
        if (best >= 0) begin
          slot = best;
          r.hit = 1'b1;
          r.status = STATUS_FOUND;
        end else begin
          r.status = STATUS_NOT_FOUND;
        end
      end
    endcase
    if (slot >= 0) begin
      r.addr   = tbl_addr[slot];
      r.prefix = tbl_prefix[slot];
      r.vip    = tbl_vip[slot];
    end
    return r;
  endfunction

  task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                            input logic [PREFIX_W-1:0] plen, input logic [VIP_W-1:0] vip);
    lpm_word_t w;
    w.command       = cmd;
    w.address       = addr;
    w.prefix_length = plen;
    w.virtual_ip    = vip;
    pending_words.push_back(w);
  endtask

  // mostly addresses near a few subnets so that covers and deletes hit
  function automatic logic [ADDR_W-1:0] pick_address();
    int sh;
    if ($urandom_range(0, 9) < 7) begin
      sh = $urandom_range(0, 24);
      return addr_pool[$urandom_range(0, POOL_SIZE - 1)] ^ ($urandom & ((32'h1 << sh) - 32'h1));
    end
    return $urandom;
  endfunction

  function automatic logic [PREFIX_W-1:0] pick_prefix();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 8) return PREFIX_W'($urandom_range(33, 63));
    if (r < 30) return PREFIX_MAX;
    return PREFIX_W'($urandom_range(1, 31));
  endfunction

  function automatic logic [CMD_W-1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 38) return CMD_UPDATE_ADD;
    if (r < 70) return CMD_LOOKUP;
    if (r < 93) return CMD_DELETE;
    return CMD_SPARE;
  endfunction

  // driver: offers pending words, holds each until accepted
  lpm_word_t cur_word;
  int        send_gap = 0;

  always @(posedge clk) begin : driver
    logic holding;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        expected_matches.push_back(match_and_update(cur_word));
        n_accepted++;
        holding = 1'b0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          cur_word = pending_words.pop_front();
          command       <= cur_word.command;
          address       <= cur_word.address;
          prefix_length <= cur_word.prefix_length;
          virtual_ip    <= cur_word.virtual_ip;
          in_valid      <= 1'b1;
          if (pending_words.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
      quiet <= (pending_words.size() <= QUIET_TAIL);
    end
  end

  // monitor: checks each result word against the oldest prediction
  int stall = 0;

  always @(posedge clk) begin : monitor
    lpm_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (expected_matches.size() == 0) begin
          $error("result word with no prediction waiting");
          errors++;
        end else begin
          want = expected_matches.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, hit);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
          if (match_address !== want.addr) begin
            $error("match_address: expected %h, actual %h", want.addr, match_address);
            errors++;
          end
          if (match_prefix !== want.prefix) begin
            $error("match_prefix: expected %0d, actual %0d", want.prefix, match_prefix);
            errors++;
          end
          if (match_vip !== want.vip) begin
            $error("match_vip: expected %h, actual %h", want.vip, match_vip);
            errors++;
          end
        end
        // long hold-off so that the block backs up into its input
        if (n_results == PRESSURE_AT) stall = PRESSURE_CYCLES;
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 12) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ipv4_longest_prefix_table_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    int k;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i]  = 1'b0;
      tbl_addr[i]   = '0;
      tbl_prefix[i] = '0;
      tbl_vip[i]    = '0;
    end
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;

    // misses on the empty table, spare command included
    queue_word(CMD_LOOKUP, 32'hFFFFFFFF, 6'd0, 32'h0);
    queue_word(CMD_DELETE, 32'h00000000, 6'd63, 32'hFFFFFFFF);
    queue_word(CMD_SPARE, 32'h01020304, 6'd0, 32'h0);
    // inserts, long prefixes saturate to 32
    queue_word(CMD_UPDATE_ADD, 32'hC0A80100, 6'd24, 32'hFFFFFFFF);
    queue_word(CMD_UPDATE_ADD, 32'h0A000000, 6'd8, 32'h00000000);
    queue_word(CMD_UPDATE_ADD, 32'hFFFFFFFF, 6'd63, 32'h12345678);
    queue_word(CMD_UPDATE_ADD, 32'h00000000, 6'd33, 32'h9ABCDEF0);
    queue_word(CMD_LOOKUP, 32'hC0A801FF, 6'd0, 32'h0);
    // update of a covered entry ignores the new prefix
    queue_word(CMD_UPDATE_ADD, 32'hC0A80155, 6'd5, 32'hAAAAAAAA);
    queue_word(CMD_UPDATE_ADD, 32'h80000000, 6'd1, 32'h55555555);
    // longest prefix wins over the /1
    queue_word(CMD_SPARE, 32'hC0A80101, 6'd0, 32'h0);
    queue_word(CMD_DELETE, 32'hC0A80199, 6'd0, 32'h0);
    queue_word(CMD_LOOKUP, 32'hC0A80199, 6'd0, 32'h0);
    // fill the table, then one insert too many
    for (k = 1; k <= TABLE_ENTRIES - 4; k++) begin
      queue_word(CMD_UPDATE_ADD, 32'h30000000 + k, PREFIX_MAX, $urandom);
    end
    queue_word(CMD_UPDATE_ADD, 32'h40000000, 6'd16, 32'h0BADF00D);
    // free a slot and insert a zero prefix that covers everything
    queue_word(CMD_DELETE, 32'h30000001, 6'd0, 32'h0);
    queue_word(CMD_UPDATE_ADD, 32'h40000000, 6'd0, 32'hCAFE0001);
    queue_word(CMD_LOOKUP, 32'h5A5A5A5A, 6'd0, 32'h0);

    // random traffic over a small address pool
    while (pending_words.size() < TOTAL_WORDS) begin
      queue_word(pick_command(), pick_address(), pick_prefix(), $urandom);
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (!(n_accepted == TOTAL_WORDS && expected_matches.size() == 0)) @(posedge clk);
    repeat (TABLE_ENTRIES + 20) @(posedge clk);
    if (errors == 0) begin
      $display("ipv4_longest_prefix_table_tb OK");
    end else begin
      $display("ipv4_longest_prefix_table_tb NOT OK");
    end
    $finish;
  end

endmodule
